/* rtl/core/lppt_pkg.sv */
// Shared constants, codes and interface structs of the LRU page pinning table.
package lppt_pkg;

  // Table geometry.
  localparam int CAPACITY  = 16;
  localparam int CAP_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int MAX_W     = 5;
  localparam int LIM_W     = (CNT_W > MAX_W) ? CNT_W : MAX_W;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 8;
  localparam int OP_W      = 2;
  localparam int KIND_W    = 3;

  localparam logic [CAP_W-1:0]  LAST_IDX       = CAP_W'(CAPACITY - 1);
  localparam logic [MAX_W-1:0]  MAX_PAGES_RST  = MAX_W'(16);
  localparam logic [DATA_W-1:0] PAGE_BYTES_RST = DATA_W'(4096);
  localparam logic [DATA_W-1:0] FIRST_ID       = DATA_W'(1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAGES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_BYTES = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_PIN   = 2'd0,
    OP_UNPIN = 2'd1,
    OP_DIRTY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_HIT     = 3'd0,
    KIND_ALLOC   = 3'd1,
    KIND_REFUSED = 3'd2,
    KIND_EVICT   = 3'd3,
    KIND_DONE    = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_EVSCAN,
    ST_EVEMIT,
    ST_FREESCAN,
    ST_ALLOC,
    ST_CLEAR
  } state_t;

  // Update command from the sequencer to the entry table.
  typedef struct packed {
    logic             clear;
    logic             alloc;
    logic             touch;
    logic             mark_dirty;
    logic             evict;
    logic [CAP_W-1:0] idx;
    logic [CAP_W-1:0] rank;
  } tbl_cmd_t;

  // One entry as seen through the table's scan port.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] pos;
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] bytes;
    logic              dirty;
    logic [CAP_W-1:0]  rank;
  } tbl_rd_t;

endpackage

/* rtl/core/lppt_table.sv */
// Entry storage of the page table: valid bits, page records and recency ranks.
module lppt_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lppt_pkg::CAP_W-1:0]  rd_idx,
  output lppt_pkg::tbl_rd_t         rd,
  input  lppt_pkg::tbl_cmd_t        cmd,
  input  logic [lppt_pkg::DATA_W-1:0] wr_pos,
  input  logic [lppt_pkg::DATA_W-1:0] wr_id,
  input  logic [lppt_pkg::DATA_W-1:0] wr_bytes
);
  import lppt_pkg::*;

  logic [CAPACITY-1:0] valid_r;
  logic [DATA_W-1:0]   pos_r   [CAPACITY];
  logic [DATA_W-1:0]   id_r    [CAPACITY];
  logic [DATA_W-1:0]   bytes_r [CAPACITY];
  logic                dirty_r [CAPACITY];
  logic [CAP_W-1:0]    rank_r  [CAPACITY];

  assign rd.valid = valid_r[rd_idx];
  assign rd.pos   = pos_r[rd_idx];
  assign rd.id    = id_r[rd_idx];
  assign rd.bytes = bytes_r[rd_idx];
  assign rd.dirty = dirty_r[rd_idx];
  assign rd.rank  = rank_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
    end else if (cmd.alloc) begin
      valid_r[cmd.idx] <= 1'b1;
    end else if (cmd.evict) begin
      valid_r[cmd.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      pos_r[cmd.idx]   <= wr_pos;
      id_r[cmd.idx]    <= wr_id;
      bytes_r[cmd.idx] <= wr_bytes;
      dirty_r[cmd.idx] <= 1'b0;
    end else if (cmd.mark_dirty) begin
      dirty_r[cmd.idx] <= 1'b1;
    end
  end

  // Each rank cell ages on its own; the touched or new entry becomes rank zero.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.touch) begin
        if (CAP_W'(i) == cmd.idx) begin
          rank_r[i] <= '0;
        end else if (valid_r[i] && (rank_r[i] < cmd.rank)) begin
          rank_r[i] <= rank_r[i] + CAP_W'(1);
        end
      end else if (cmd.alloc) begin
        if (CAP_W'(i) == cmd.idx) begin
          rank_r[i] <= '0;
        end else if (valid_r[i]) begin
          rank_r[i] <= rank_r[i] + CAP_W'(1);
        end
      end
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.alloc, cmd.touch, cmd.mark_dirty, cmd.evict}))
    else $error("table received more than one update at once");

  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !valid_r[cmd.idx])
    else $error("allocation into an occupied slot");

  a_evict_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evict |-> valid_r[cmd.idx])
    else $error("eviction of an empty slot");

  a_touch_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.touch || cmd.mark_dirty) |-> valid_r[cmd.idx])
    else $error("touch or dirty mark of an empty slot");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (valid_r == '0))
    else $error("table not empty after clear");

endmodule

/* rtl/core/lru_page_pinning_table_top.sv */
// Top level of the LRU page pinning table: request sequencer, configuration and result register.
//
// A fully associative table of up to 16 resident pages kept in least-recently-used
// order. A pin request searches by sequence position; a hit makes the page most recent
// and returns its id, a miss evicts least recent pages (one eviction result each, with
// last low) until the resident count is below max_pages capped at the table size, then
// allocates the next id from a counter that starts at 1 and skips 0, and returns it with
// last high. A miss with max_pages at zero is refused. Unpin makes a page most recent
// by id, mark-dirty sets its dirty flag, and clear empties the table and restarts the id
// counter. Every result carries the resident count after it. The block handles one
// request at a time: a single comparator walks the entries one per cycle, so timing is
// set by that scan and by any wait for the consumer to take an earlier result. A search
// stops at the first match, a miss has walked every entry, each eviction scans the whole
// table for the least recent page, and an allocation walks to the first free slot. The
// next request is accepted in the cycle after the last result has been loaded, even
// while that result still waits at the output. Configuration writes are always taken,
// but should only be issued while no request is in progress.
module lru_page_pinning_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lppt_pkg::OP_W-1:0]     in_op,
  input  logic [lppt_pkg::DATA_W-1:0]   in_seq_pos,
  input  logic [lppt_pkg::DATA_W-1:0]   in_page_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lppt_pkg::KIND_W-1:0]   out_kind,
  output logic                          out_found,
  output logic [lppt_pkg::DATA_W-1:0]   out_result_id,
  output logic [lppt_pkg::DATA_W-1:0]   out_result_pos,
  output logic [lppt_pkg::DATA_W-1:0]   out_result_bytes,
  output logic                          out_result_dirty,
  output logic [lppt_pkg::CNT_W-1:0]    out_resident_count,
  output logic                          out_last,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lppt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lppt_pkg::DATA_W-1:0]   cfg_wdata
);
  import lppt_pkg::*;

  // Control state.
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [DATA_W-1:0]  next_id_r, next_id_nxt;
  logic [MAX_W-1:0]   max_pages_r;
  logic [DATA_W-1:0]  page_bytes_r;

  // Request and working registers.
  op_t                op_r;
  logic [DATA_W-1:0]  pos_r;
  logic [DATA_W-1:0]  id_r;
  logic [CAP_W-1:0]   idx_r, idx_nxt;
  logic [CAP_W-1:0]   tgt_r, tgt_nxt;
  logic               cap_v_r, cap_v_nxt;
  logic [CAP_W-1:0]   cap_rank_r, cap_rank_nxt;
  logic [DATA_W-1:0]  cap_id_r, cap_id_nxt;
  logic [DATA_W-1:0]  cap_pos_r, cap_pos_nxt;
  logic [DATA_W-1:0]  cap_bytes_r, cap_bytes_nxt;
  logic               cap_dirty_r, cap_dirty_nxt;

  // Result register.
  kind_t              out_kind_r, out_kind_nxt;
  logic               out_found_r, out_found_nxt;
  logic [DATA_W-1:0]  out_id_r, out_id_nxt;
  logic [DATA_W-1:0]  out_pos_r, out_pos_nxt;
  logic [DATA_W-1:0]  out_bytes_r, out_bytes_nxt;
  logic               out_dirty_r, out_dirty_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;
  logic               load_out;

  logic               in_fire;
  logic               slot_free;
  logic               match;
  logic [DATA_W-1:0]  key;
  logic [DATA_W-1:0]  fld;
  logic [LIM_W-1:0]   limit;
  logic [CNT_W-1:0]   count_dec;
  tbl_cmd_t           tbl_cmd;
  tbl_rd_t            tbl_rd;

  lppt_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx_r),
    .rd       (tbl_rd),
    .cmd      (tbl_cmd),
    .wr_pos   (pos_r),
    .wr_id    (next_id_r),
    .wr_bytes (page_bytes_r)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // The shared comparator: position for a pin, id for unpin and mark-dirty.
  assign key   = (op_r == OP_PIN) ? pos_r : id_r;
  assign fld   = (op_r == OP_PIN) ? tbl_rd.pos : tbl_rd.id;
  assign match = tbl_rd.valid && (key == fld);

  // A limit above the table size behaves as the table size.
  assign limit = (LIM_W'(max_pages_r) > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY)
                                                           : LIM_W'(max_pages_r);
  assign count_dec = count_r - CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    next_id_nxt   = next_id_r;
    idx_nxt       = idx_r;
    tgt_nxt       = tgt_r;
    cap_v_nxt     = cap_v_r;
    cap_rank_nxt  = cap_rank_r;
    cap_id_nxt    = cap_id_r;
    cap_pos_nxt   = cap_pos_r;
    cap_bytes_nxt = cap_bytes_r;
    cap_dirty_nxt = cap_dirty_r;
    tbl_cmd       = '0;
    tbl_cmd.idx   = tgt_r;
    tbl_cmd.rank  = cap_rank_r;
    load_out      = 1'b0;
    out_kind_nxt  = KIND_DONE;
    out_found_nxt = 1'b0;
    out_id_nxt    = '0;
    out_pos_nxt   = '0;
    out_bytes_nxt = '0;
    out_dirty_nxt = 1'b0;
    out_count_nxt = count_r;
    out_last_nxt  = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt   = '0;
          state_nxt = (op_t'(in_op) == OP_CLEAR) ? ST_CLEAR : ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (match) begin
          tgt_nxt      = idx_r;
          cap_id_nxt   = tbl_rd.id;
          cap_rank_nxt = tbl_rd.rank;
          state_nxt    = ST_HIT;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_MISS;
        end else begin
          idx_nxt = idx_r + CAP_W'(1);
        end
      end

      ST_HIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (op_r == OP_DIRTY) begin
            tbl_cmd.mark_dirty = 1'b1;
          end else begin
            tbl_cmd.touch = 1'b1;
          end
          if (op_r == OP_PIN) begin
            out_kind_nxt = KIND_HIT;
            out_id_nxt   = cap_id_r;
            out_pos_nxt  = pos_r;
          end else begin
            out_found_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_MISS: begin
        if (op_r != OP_PIN) begin
          if (slot_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (max_pages_r == '0) begin
          if (slot_free) begin
            load_out     = 1'b1;
            out_kind_nxt = KIND_REFUSED;
            state_nxt    = ST_IDLE;
          end
        end else begin
          idx_nxt   = '0;
          cap_v_nxt = 1'b0;
          state_nxt = (LIM_W'(count_r) >= limit) ? ST_EVSCAN : ST_FREESCAN;
        end
      end

      // Least recent entry: the valid one with the highest rank.
      ST_EVSCAN: begin
        if (tbl_rd.valid && (!cap_v_r || (tbl_rd.rank > cap_rank_r))) begin
          cap_v_nxt     = 1'b1;
          tgt_nxt       = idx_r;
          cap_rank_nxt  = tbl_rd.rank;
          cap_id_nxt    = tbl_rd.id;
          cap_pos_nxt   = tbl_rd.pos;
          cap_bytes_nxt = tbl_rd.bytes;
          cap_dirty_nxt = tbl_rd.dirty;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_EVEMIT;
        end else begin
          idx_nxt = idx_r + CAP_W'(1);
        end
      end

      ST_EVEMIT: begin
        if (slot_free) begin
          load_out      = 1'b1;
          tbl_cmd.evict = 1'b1;
          out_kind_nxt  = KIND_EVICT;
          out_id_nxt    = cap_id_r;
          out_pos_nxt   = cap_pos_r;
          out_bytes_nxt = cap_bytes_r;
          out_dirty_nxt = cap_dirty_r;
          out_count_nxt = count_dec;
          out_last_nxt  = 1'b0;
          count_nxt     = count_dec;
          idx_nxt       = '0;
          cap_v_nxt     = 1'b0;
          state_nxt     = (LIM_W'(count_dec) >= limit) ? ST_EVSCAN : ST_FREESCAN;
        end
      end

      ST_FREESCAN: begin
        if (!tbl_rd.valid || (idx_r == LAST_IDX)) begin
          tgt_nxt   = idx_r;
          state_nxt = ST_ALLOC;
        end else begin
          idx_nxt = idx_r + CAP_W'(1);
        end
      end

      ST_ALLOC: begin
        if (slot_free) begin
          load_out      = 1'b1;
          tbl_cmd.alloc = 1'b1;
          out_kind_nxt  = KIND_ALLOC;
          out_id_nxt    = next_id_r;
          out_pos_nxt   = pos_r;
          out_count_nxt = count_r + CNT_W'(1);
          count_nxt     = count_r + CNT_W'(1);
          // Zero is kept as the refused code, so the counter wraps to one.
          next_id_nxt   = (next_id_r == '1) ? FIRST_ID : next_id_r + DATA_W'(1);
          state_nxt     = ST_IDLE;
        end
      end

      ST_CLEAR: begin
        if (slot_free) begin
          load_out      = 1'b1;
          tbl_cmd.clear = 1'b1;
          count_nxt     = '0;
          next_id_nxt   = FIRST_ID;
          out_count_nxt = '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      count_r      <= '0;
      next_id_r    <= FIRST_ID;
      max_pages_r  <= MAX_PAGES_RST;
      page_bytes_r <= PAGE_BYTES_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_PAGES) begin
          max_pages_r <= cfg_wdata[MAX_W-1:0];
        end else if (cfg_index == REG_PAGE_BYTES) begin
          page_bytes_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= op_t'(in_op);
      pos_r <= in_seq_pos;
      id_r  <= in_page_id;
    end
    idx_r       <= idx_nxt;
    tgt_r       <= tgt_nxt;
    cap_v_r     <= cap_v_nxt;
    cap_rank_r  <= cap_rank_nxt;
    cap_id_r    <= cap_id_nxt;
    cap_pos_r   <= cap_pos_nxt;
    cap_bytes_r <= cap_bytes_nxt;
    cap_dirty_r <= cap_dirty_nxt;
    if (load_out) begin
      out_kind_r  <= out_kind_nxt;
      out_found_r <= out_found_nxt;
      out_id_r    <= out_id_nxt;
      out_pos_r   <= out_pos_nxt;
      out_bytes_r <= out_bytes_nxt;
      out_dirty_r <= out_dirty_nxt;
      out_count_r <= out_count_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_found          = out_found_r;
  assign out_result_id      = out_id_r;
  assign out_result_pos     = out_pos_r;
  assign out_result_bytes   = out_bytes_r;
  assign out_result_dirty   = out_dirty_r;
  assign out_resident_count = out_count_r;
  assign out_last           = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("resident count above table size");

  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVEMIT) |-> (cap_v_r && (count_r != '0)))
    else $error("eviction without a resident victim");

  a_alloc_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALLOC) |-> (LIM_W'(count_r) < limit))
    else $error("allocation with the table at its limit");

  a_only_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && !out_last_nxt) |-> (out_kind_nxt == KIND_EVICT))
    else $error("non-final result that is not an eviction");

  a_request_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("accepted request left the sequencer idle");

endmodule
